// ----- rtl/shp3_pkg.sv -----
// ----------------------------------------------------------------------------
// shp3_pkg
// Shared constants for the 3x3 sharpen stencil: register map, field widths,
// operation codes and reset values.
// ----------------------------------------------------------------------------
package shp3_pkg;

  // default sizing
  localparam int unsigned MaxWidthDef    = 1024;
  localparam int unsigned MaxChannelsDef = 4;

  // register field widths
  localparam int unsigned WidthW  = 11;
  localparam int unsigned HeightW = 12;
  localparam int unsigned ChansW  = 3;
  localparam int unsigned CfgW    = 12;
  localparam int unsigned CfgIdxW = 2;

  // register map
  localparam logic [CfgIdxW-1:0] RegWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegChans  = 2'd2;

  // legal ranges
  localparam int unsigned WidthMin    = 3;
  localparam int unsigned WidthFieldMax = 2047;
  localparam int unsigned HeightMin   = 3;
  localparam int unsigned HeightMax   = 4095;
  localparam int unsigned ChansMin    = 1;

  // reset values
  localparam int unsigned WidthRst  = 640;
  localparam int unsigned HeightRst = 480;
  localparam int unsigned ChansRst  = 3;

  // operation codes
  localparam logic OpSample = 1'b0;
  localparam logic OpFlush  = 1'b1;

  // sample width
  localparam int unsigned PixW = 8;

endpackage

// ----- rtl/sharpen_3x3_stencil.sv -----
// ----------------------------------------------------------------------------
// sharpen_3x3_stencil
// Streaming 3x3 Laplacian sharpen (5*centre minus four neighbours, clamped)
// over a raster of interleaved 8-bit channel samples.
// ----------------------------------------------------------------------------
// usage:
//   input channel: one word per sample (op=sample) or flush tick (op=flush),
//   valid/ready handshake; output channel: value and last, valid/ready
// throughput: one word per cycle in steady state while the output does not stall;
//   the line memory takes one read on accept and one write-back from stage 1,
//   on separate ports, so the rate stays at one word per cycle
// result path: the word that completes a neighbourhood passes through the stage 1
//   register and the output register (two register stages); in stream
//   terms a sample's result leaves one row plus one pixel
//   (width*channels + channels words) later
// flush: each flush word drains one pending result with value zero, so a
//   frame ends with width*channels + channels flush words; last marks the
//   final sample position of the frame
// stall: the output register holds while the receiver is not ready; the
//   pipeline keeps accepting words that give no result, and stalls the input
//   only when a result would have to overwrite a waiting one
// reset: registers go to 640 x 480 x 3, counters and pending results clear;
//   the line memory is left undefined and is only read for border positions
//   before being written
// config: a write clamps the value to its range and restarts the frame
// ----------------------------------------------------------------------------
module sharpen_3x3_stencil
  import shp3_pkg::*;
#(
  parameter int unsigned MAX_WIDTH    = MaxWidthDef,
  parameter int unsigned MAX_CHANNELS = MaxChannelsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  // input words
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic [PixW-1:0]    sample_i,
  // result words
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [PixW-1:0]    value_o,
  output logic               last_o
);

  // effective max width is bounded by the 11-bit register field
  localparam int unsigned WMax   = (MAX_WIDTH < WidthFieldMax) ? MAX_WIDTH : WidthFieldMax;
  localparam int unsigned Depth  = MAX_WIDTH * MAX_CHANNELS;
  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned PxW    = $clog2(WMax);
  localparam int unsigned ChW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned PendW  = $clog2((WMax + 1) * MAX_CHANNELS + 1);
  localparam int unsigned DlyW   = 15;
  localparam int unsigned AccW   = 13;

  localparam logic [WidthW-1:0]  WidthRstC = WidthW'((WidthRst < WMax) ? WidthRst : WMax);
  localparam logic [ChansW-1:0]  ChansRstC =
    ChansW'((ChansRst < MAX_CHANNELS) ? ChansRst : MAX_CHANNELS);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic [ChansW-1:0]  chans_q;

  logic [WidthW-1:0]  cfg_width;
  logic [HeightW-1:0] cfg_height;
  logic [ChansW-1:0]  cfg_chans;
  logic               cfg_hit;

  always_comb begin
    cfg_width  = cfg_data_i[WidthW-1:0];
    cfg_height = cfg_data_i[HeightW-1:0];
    cfg_chans  = cfg_data_i[ChansW-1:0];
    if (cfg_width < WidthW'(WidthMin)) cfg_width = WidthW'(WidthMin);
    else if (cfg_width > WidthW'(WMax)) cfg_width = WidthW'(WMax);
    if (cfg_height < HeightW'(HeightMin)) cfg_height = HeightW'(HeightMin);
    else if (cfg_height > HeightW'(HeightMax)) cfg_height = HeightW'(HeightMax);
    if (cfg_chans < ChansW'(ChansMin)) cfg_chans = ChansW'(ChansMin);
    else if (cfg_chans > ChansW'(MAX_CHANNELS)) cfg_chans = ChansW'(MAX_CHANNELS);
    // index beyond the map is ignored and does not restart the frame
    cfg_hit = cfg_we_i && (cfg_idx_i == RegWidth || cfg_idx_i == RegHeight ||
                           cfg_idx_i == RegChans);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRstC;
      height_q <= HeightW'(HeightRst);
      chans_q  <= ChansRstC;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegWidth:  width_q  <= cfg_width;
        RegHeight: height_q <= cfg_height;
        RegChans:  chans_q  <= cfg_chans;
        default:   ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // handshake and pipeline control
  // --------------------------------------------------------------------------
  logic               s1_valid_q;
  logic               s1_op_q;
  logic               s1_emit_q;
  logic               s1_zero_q;
  logic               s1_last_q;
  logic [PixW-1:0]    s1_sample_q;
  logic [AddrW-1:0]   s1_x_q;
  logic [ChW-1:0]     s1_ch_q;

  logic               out_valid_q;
  logic [PixW-1:0]    value_q;
  logic               last_q;

  logic s1_stall, s1_fire, in_fire, is_sample;

  // stage 1 only blocks when its result would land on a waiting one
  assign s1_stall   = s1_valid_q && s1_emit_q && out_valid_q && !out_ready_i;
  assign s1_fire    = s1_valid_q && !s1_stall;
  assign in_ready_o = !s1_stall;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_sample  = (op_i == OpSample);

  // --------------------------------------------------------------------------
  // input position counters (channel, pixel, row, line address)
  // --------------------------------------------------------------------------
  logic [ChW-1:0]     in_ch_q, in_ch_d;
  logic [PxW-1:0]     in_px_q, in_px_d;
  logic [HeightW-1:0] in_row_q, in_row_d;
  logic [AddrW-1:0]   x_q, x_d;

  logic [ChansW-1:0]  chans_m1;
  logic [WidthW-1:0]  width_m1;
  logic [HeightW-1:0] height_m1;

  assign chans_m1  = chans_q - ChansW'(1);
  assign width_m1  = width_q - WidthW'(1);
  assign height_m1 = height_q - HeightW'(1);

  always_comb begin
    in_ch_d  = in_ch_q;
    in_px_d  = in_px_q;
    in_row_d = in_row_q;
    x_d      = x_q + AddrW'(1);
    if (ChansW'(in_ch_q) == chans_m1) begin
      in_ch_d = '0;
      if (WidthW'(in_px_q) == width_m1) begin
        in_px_d = '0;
        x_d     = '0;
        if (in_row_q == height_m1) in_row_d = '0;
        else                       in_row_d = in_row_q + HeightW'(1);
      end else begin
        in_px_d = in_px_q + PxW'(1);
      end
    end else begin
      in_ch_d = in_ch_q + ChW'(1);
    end
  end

  // --------------------------------------------------------------------------
  // output position counters and pending results
  // --------------------------------------------------------------------------
  logic [ChW-1:0]     out_ch_q, out_ch_d;
  logic [PxW-1:0]     out_px_q, out_px_d;
  logic [HeightW-1:0] out_row_q, out_row_d;
  logic [PendW-1:0]   pend_q;
  logic [DlyW-1:0]    delay_full;
  logic [PendW-1:0]   delay;
  logic               emit, border, at_last;

  // a result leaves (width + 1) * channels words after its own sample
  assign delay_full = (DlyW'(width_q) + DlyW'(1)) * DlyW'(chans_q);
  assign delay      = PendW'(delay_full);
  assign emit       = is_sample ? (pend_q >= delay) : (pend_q != '0);

  assign border  = (out_row_q == '0) || (out_row_q >= height_m1) ||
                   (out_px_q == '0) || (WidthW'(out_px_q) >= width_m1);
  assign at_last = (out_row_q == height_m1) && (WidthW'(out_px_q) == width_m1) &&
                   (ChansW'(out_ch_q) == chans_m1);

  always_comb begin
    out_ch_d  = out_ch_q;
    out_px_d  = out_px_q;
    out_row_d = out_row_q;
    if (ChansW'(out_ch_q) == chans_m1) begin
      out_ch_d = '0;
      if (WidthW'(out_px_q) == width_m1) begin
        out_px_d = '0;
        if (out_row_q == height_m1) out_row_d = '0;
        else                        out_row_d = out_row_q + HeightW'(1);
      end else begin
        out_px_d = out_px_q + PxW'(1);
      end
    end else begin
      out_ch_d = out_ch_q + ChW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch_q   <= '0;
      in_px_q   <= '0;
      in_row_q  <= '0;
      x_q       <= '0;
      out_ch_q  <= '0;
      out_px_q  <= '0;
      out_row_q <= '0;
      pend_q    <= '0;
    end else if (cfg_hit) begin
      in_ch_q   <= '0;
      in_px_q   <= '0;
      in_row_q  <= '0;
      x_q       <= '0;
      out_ch_q  <= '0;
      out_px_q  <= '0;
      out_row_q <= '0;
      pend_q    <= '0;
    end else if (in_fire) begin
      if (is_sample) begin
        in_ch_q  <= in_ch_d;
        in_px_q  <= in_px_d;
        in_row_q <= in_row_d;
        x_q      <= x_d;
        if (!emit) pend_q <= pend_q + PendW'(1);
      end else if (emit) begin
        pend_q <= pend_q - PendW'(1);
      end
      if (emit) begin
        out_ch_q  <= out_ch_d;
        out_px_q  <= out_px_d;
        out_row_q <= out_row_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 1 register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q     <= op_i;
      s1_emit_q   <= emit;
      // flush words always drain a zero
      s1_zero_q   <= border || !is_sample;
      s1_last_q   <= at_last;
      s1_sample_q <= sample_i;
      s1_x_q      <= x_q;
      s1_ch_q     <= in_ch_q;
    end
  end

  // --------------------------------------------------------------------------
  // line memory: {row above, middle row} per sample column
  // read on accept, written back from stage 1
  // --------------------------------------------------------------------------
  logic [2*PixW-1:0] line_mem [Depth];
  logic [2*PixW-1:0] rd_q;
  logic [PixW-1:0]   rd_above, rd_mid;

  assign rd_above = rd_q[2*PixW-1:PixW];
  assign rd_mid   = rd_q[PixW-1:0];

  always_ff @(posedge clk_i) begin
    if (in_fire && is_sample) begin
      rd_q <= line_mem[x_q];
    end
    if (s1_fire && s1_op_q == OpSample) begin
      line_mem[s1_x_q] <= {rd_mid, s1_sample_q};
    end
  end

  // --------------------------------------------------------------------------
  // per-channel window: last column (above, middle, below) and the middle
  // sample of the column before it
  // --------------------------------------------------------------------------
  logic [PixW-1:0] win_up_q   [MAX_CHANNELS];
  logic [PixW-1:0] win_mid_q  [MAX_CHANNELS];
  logic [PixW-1:0] win_dn_q   [MAX_CHANNELS];
  logic [PixW-1:0] win_left_q [MAX_CHANNELS];

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_op_q == OpSample) begin
      win_left_q[s1_ch_q] <= win_mid_q[s1_ch_q];
      win_up_q[s1_ch_q]   <= rd_above;
      win_mid_q[s1_ch_q]  <= rd_mid;
      win_dn_q[s1_ch_q]   <= s1_sample_q;
    end
  end

  // --------------------------------------------------------------------------
  // stencil: 5*centre - left - right - up - down, clamped to 0..255
  // --------------------------------------------------------------------------
  logic signed [AccW-1:0] c_s, l_s, r_s, u_s, d_s, acc;
  logic [PixW-1:0]        sharp;

  always_comb begin
    c_s = $signed({{(AccW-PixW){1'b0}}, win_mid_q[s1_ch_q]});
    l_s = $signed({{(AccW-PixW){1'b0}}, win_left_q[s1_ch_q]});
    r_s = $signed({{(AccW-PixW){1'b0}}, rd_mid});
    u_s = $signed({{(AccW-PixW){1'b0}}, win_up_q[s1_ch_q]});
    d_s = $signed({{(AccW-PixW){1'b0}}, win_dn_q[s1_ch_q]});
    acc = (c_s <<< 2) + c_s - l_s - r_s - u_s - d_s;
    if (acc < 0)                                sharp = '0;
    else if (acc > $signed(AccW'(255)))         sharp = '1;
    else                                        sharp = acc[PixW-1:0];
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_emit_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_emit_q) begin
      value_q <= s1_zero_q ? '0 : sharp;
      last_q  <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign last_o      = last_q;

endmodule
